/* rtl/gbpfl_pkg.sv */
package gbpfl_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int PTR_W      = $clog2(POOL_DEPTH);
    localparam int DEPTH_W    = PTR_W + 1;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int STAT_W     = 32;
    localparam int CFG_AW     = 2;

    localparam logic [CNT_W-1:0] USED_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] RST_INITIAL = 11'd256;
    localparam logic [CNT_W-1:0] RST_MAX     = 11'd1024;
    localparam logic [CNT_W-1:0] RST_GROW    = 11'd256;

    localparam logic [CFG_AW-1:0] CFG_INITIAL = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_GROW    = 2'd2;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_GRANTED    = 3'd0,
        ST_RELEASED   = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_INVALID    = 3'd3,
        ST_STACK_FULL = 3'd4
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  granted;
        logic [CNT_W-1:0]  in_use;
        logic [CNT_W-1:0]  peak;
        logic [CNT_W-1:0]  total;
        logic [STAT_W-1:0] acq_cnt;
        logic [STAT_W-1:0] rel_cnt;
        logic [STAT_W-1:0] fail_cnt;
        logic [STAT_W-1:0] exp_cnt;
    } t_result;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] data;
    } t_stack_cmd;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [IDX_W-1:0] top;
    } t_stack_stat;

    function automatic logic [CNT_W-1:0] clamp_depth(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(POOL_DEPTH);
        return (v > lim) ? lim : v;
    endfunction

endpackage

/* rtl/gbpfl_stack.sv */
module gbpfl_stack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gbpfl_pkg::t_stack_cmd    i_cmd,
    output gbpfl_pkg::t_stack_stat   o_stat
);
    import gbpfl_pkg::*;

    // The top entry lives in r_top; the memory holds the entries below it.
    // Each cycle the entry that would become the top after a pop is read ahead.
    logic [IDX_W-1:0]   r_mem [POOL_DEPTH];
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [IDX_W-1:0]   r_top, n_top;
    logic [IDX_W-1:0]   r_mem_q;
    logic [IDX_W-1:0]   r_fwd_data;
    logic               r_fwd;
    logic [IDX_W-1:0]   rd_val;
    logic               push, pop, wr_en;
    logic [PTR_W-1:0]   wr_addr, rd_addr;

    assign push    = i_cmd.push && !i_cmd.clear;
    assign pop     = i_cmd.pop && !i_cmd.clear;
    assign wr_en   = push && (r_depth != '0);
    assign wr_addr = PTR_W'(r_depth - DEPTH_W'(1));
    assign rd_val  = r_fwd ? r_fwd_data : r_mem_q;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (push) begin
            n_depth = r_depth + DEPTH_W'(1);
            n_top   = i_cmd.data;
        end else if (pop) begin
            n_depth = r_depth - DEPTH_W'(1);
            n_top   = rd_val;
        end
    end

    assign rd_addr = PTR_W'(n_depth - DEPTH_W'(2));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
        r_mem_q    <= r_mem[rd_addr];
        r_fwd_data <= r_top;
        r_top      <= n_top;
    end

    // A push writes the old top exactly where the next read-ahead points.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_fwd   <= wr_en;
        end
    end

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth >= DEPTH_W'(POOL_DEPTH));
    assign o_stat.top   = r_top;

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("stack push and pop in the same cycle");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(POOL_DEPTH))
        else $error("stack depth above capacity");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_depth != '0)
        else $error("pop from empty stack");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_top == $past(i_cmd.data))
        else $error("pushed word not on top");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_depth == '0)
        else $error("stack not empty after clear");

endmodule

/* rtl/gbpfl_ctrl.sv */
module gbpfl_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbpfl_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [gbpfl_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  logic                                i_fire,
    input  gbpfl_pkg::t_req                     i_req,
    input  gbpfl_pkg::t_stack_stat              i_stack,
    output gbpfl_pkg::t_stack_cmd               o_stack,
    output gbpfl_pkg::t_result                  o_result
);
    import gbpfl_pkg::*;

    logic [CNT_W-1:0]  r_initial, r_max, r_grow;
    logic [CNT_W-1:0]  r_fresh_low, r_fresh_high, r_total, r_used, r_peak;
    logic [STAT_W-1:0] r_acq, r_rel, r_fail, r_exp;

    logic [CNT_W-1:0]  n_fresh_low, n_fresh_high, n_total, n_used, n_peak;
    logic [STAT_W-1:0] n_acq, n_rel, n_fail, n_exp;

    logic [CNT_W-1:0]  lim, room, grow_n, fresh_top, init_total;
    logic              need_grow, cfg_hit;
    t_status           status;
    logic [IDX_W-1:0]  granted;
    logic              push, pop;

    assign cfg_hit = i_cfg_we && (i_cfg_addr == CFG_INITIAL || i_cfg_addr == CFG_MAX ||
                                  i_cfg_addr == CFG_GROW);
    assign init_total = clamp_depth((i_cfg_addr == CFG_INITIAL) ? i_cfg_wdata : r_initial);

    assign lim       = clamp_depth(r_max);
    assign room      = (r_total >= lim) ? '0 : lim - r_total;
    assign grow_n    = (r_grow < room) ? r_grow : room;
    assign need_grow = i_stack.empty && (r_fresh_high <= r_fresh_low);

    always_comb begin
        n_fresh_low  = r_fresh_low;
        n_fresh_high = r_fresh_high;
        n_total      = r_total;
        n_used       = r_used;
        n_peak       = r_peak;
        n_acq        = r_acq;
        n_rel        = r_rel;
        n_fail       = r_fail;
        n_exp        = r_exp;
        status       = ST_GRANTED;
        granted      = '0;
        push         = 1'b0;
        pop          = 1'b0;
        fresh_top    = r_fresh_high;

        if (i_req.op == OP_ACQUIRE) begin
            if (need_grow && grow_n == '0) begin
                status = ST_EXHAUSTED;
                n_fail = r_fail + STAT_W'(1);
            end else begin
                if (need_grow) begin
                    fresh_top   = r_total + grow_n;
                    n_fresh_low = r_total;
                    n_total     = r_total + grow_n;
                    n_exp       = r_exp + STAT_W'(1);
                end
                // Returned words are served before never-issued indices.
                if (!i_stack.empty) begin
                    pop     = 1'b1;
                    granted = i_stack.top;
                end else begin
                    n_fresh_high = fresh_top - CNT_W'(1);
                    granted      = IDX_W'(fresh_top - CNT_W'(1));
                end
                n_acq  = r_acq + STAT_W'(1);
                n_used = (r_used == USED_MAX) ? r_used : r_used + CNT_W'(1);
                if (n_used > r_peak) begin
                    n_peak = n_used;
                end
            end
        end else begin
            if (CNT_W'(i_req.idx) >= r_total) begin
                status = ST_INVALID;
            end else if (i_stack.full) begin
                status = ST_STACK_FULL;
            end else begin
                status = ST_RELEASED;
                push   = 1'b1;
                n_rel  = r_rel + STAT_W'(1);
                n_used = (r_used == '0) ? r_used : r_used - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial    <= RST_INITIAL;
            r_max        <= RST_MAX;
            r_grow       <= RST_GROW;
            r_fresh_low  <= '0;
            r_fresh_high <= clamp_depth(RST_INITIAL);
            r_total      <= clamp_depth(RST_INITIAL);
            r_used       <= '0;
            r_peak       <= '0;
            r_acq        <= '0;
            r_rel        <= '0;
            r_fail       <= '0;
            r_exp        <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_addr)
                CFG_INITIAL: r_initial <= i_cfg_wdata;
                CFG_MAX:     r_max     <= i_cfg_wdata;
                CFG_GROW:    r_grow    <= i_cfg_wdata;
                default:     ;
            endcase
            r_fresh_low  <= '0;
            r_fresh_high <= init_total;
            r_total      <= init_total;
            r_used       <= '0;
            r_peak       <= '0;
            r_acq        <= '0;
            r_rel        <= '0;
            r_fail       <= '0;
            r_exp        <= '0;
        end else if (i_fire) begin
            r_fresh_low  <= n_fresh_low;
            r_fresh_high <= n_fresh_high;
            r_total      <= n_total;
            r_used       <= n_used;
            r_peak       <= n_peak;
            r_acq        <= n_acq;
            r_rel        <= n_rel;
            r_fail       <= n_fail;
            r_exp        <= n_exp;
        end
    end

    assign o_stack.clear = cfg_hit;
    assign o_stack.push  = i_fire && push;
    assign o_stack.pop   = i_fire && pop;
    assign o_stack.data  = i_req.idx;

    assign o_result.status   = status;
    assign o_result.granted  = granted;
    assign o_result.in_use   = n_used;
    assign o_result.peak     = n_peak;
    assign o_result.total    = n_total;
    assign o_result.acq_cnt  = n_acq;
    assign o_result.rel_cnt  = n_rel;
    assign o_result.fail_cnt = n_fail;
    assign o_result.exp_cnt  = n_exp;

    a_fresh_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_high <= r_total)
        else $error("fresh range runs past the pool total");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(POOL_DEPTH))
        else $error("pool total above capacity");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_peak)
        else $error("in-use count above its peak");

endmodule

/* rtl/growable_buffer_pool_free_list_top.sv */
// Channel   | Direction | Contents (lowest bit first)
// s request | in        | tuser: operation; tdata: buffer_index, pad to 16 bits
// m result  | out       | tuser: status; tdata: granted_index .. expand_count, pad to 176
// cfg       | in        | we, addr (0 initial, 1 max, 2 grow), wdata 11 bits
//
// One request per cycle while the result is not stalled: a request is captured in the
// input register, then its result is computed and loaded into the output register.
// The free stack keeps its top word in a register and reads the next one ahead from a
// memory with one write and one read port, so pops can follow each other every cycle.
// Reset is synchronous and leaves the pool at 256 indices with an empty stack.
// A stalled result holds the output and, once the input register fills, the input.
module growable_buffer_pool_free_list_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // buffer_index[9:0]
    input  logic [0:0]                       s_tuser,  // operation[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // granted_index[9:0], in_use[20:10], peak_in_use[31:21], total_buffers[42:32],
    // acquire_count[74:43], release_count[106:75], fail_count[138:107],
    // expand_count[170:139]
    output logic [175:0]                     m_tdata,
    output logic [2:0]                       m_tuser,  // status[2:0]
    input  logic                             i_cfg_we,
    input  logic [gbpfl_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [gbpfl_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import gbpfl_pkg::*;

    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_result     r_out;
    logic        fire;
    t_result     result;
    t_stack_cmd  stack_cmd;
    t_stack_stat stack_stat;

    assign fire     = r_in_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_vld <= s_tvalid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.op  <= t_op'(s_tuser[0]);
            r_in.idx <= s_tdata[IDX_W-1:0];
        end
        if (fire) begin
            r_out <= result;
        end
    end

    gbpfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_req       (r_in),
        .i_stack     (stack_stat),
        .o_stack     (stack_cmd),
        .o_result    (result)
    );

    gbpfl_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stack_cmd),
        .o_stat  (stack_stat)
    );

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.status;
    assign m_tdata  = {5'b0, r_out.exp_cnt, r_out.fail_cnt, r_out.rel_cnt, r_out.acq_cnt,
                       r_out.total, r_out.peak, r_out.in_use, r_out.granted};

    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.status != ST_GRANTED |-> r_out.granted == '0)
        else $error("index handed out without a grant");

    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed word did not reach the output register");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_tready |=> r_out_vld && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

/* dv/growable_buffer_pool_free_list_top_test.sv */
`timescale 1ns / 100ps

module growable_buffer_pool_free_list_top_test;
    import gbpfl_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_ROWS = 34;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 80;
    localparam int FILL_RELEASES = POOL_DEPTH + 6;
    localparam int DRAIN_GRANTS  = 64;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } t_ready_mode;

    typedef struct packed {
        t_row_kind         kind;
        t_op               op;
        logic [CFG_AW-1:0] addr;
        logic [CNT_W-1:0]  value;
        logic              typed;
        t_status           want_status;
        logic [IDX_W-1:0]  want_granted;
    } t_directed_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [175:0]      m_tdata;
    logic [2:0]        m_tuser;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;

    growable_buffer_pool_free_list_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Allocator mirror: configuration, free stack and statistics.
    logic [CNT_W-1:0]  cfg_initial = RST_INITIAL;
    logic [CNT_W-1:0]  cfg_max     = RST_MAX;
    logic [CNT_W-1:0]  cfg_grow    = RST_GROW;
    logic [IDX_W-1:0]  free_stack [POOL_DEPTH];
    int                stack_depth;
    int                fresh_low;
    int                fresh_high;
    int                pool_total;
    int                used_now;
    int                used_peak;
    logic [STAT_W-1:0] acq_total;
    logic [STAT_W-1:0] rel_total;
    logic [STAT_W-1:0] fail_total;
    logic [STAT_W-1:0] grow_total;

    t_result           pending_results [$];
    int                held_idx [$];
    int                mismatches = 0;
    int                results_seen = 0;
    int                burst_left = 0;
    bit                pin_result = 1'b0;
    t_status           pinned_status;
    logic [IDX_W-1:0]  pinned_granted;
    t_directed_row     directed_rows [DIRECTED_ROWS];
    t_result           seen_result;
    t_result           due_result;
    t_ready_mode       ready_mode = RDY_ALWAYS;
    logic [7:0]        ready_left = '0;

    function automatic void pool_reinit();
        stack_depth = 0;
        pool_total  = (cfg_initial > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_initial);
        fresh_low   = 0;
        fresh_high  = pool_total;
        used_now    = 0;
        used_peak   = 0;
        acq_total   = '0;
        rel_total   = '0;
        fail_total  = '0;
        grow_total  = '0;
    endfunction

    function automatic t_result allocate_or_free(t_op op, logic [IDX_W-1:0] idx);
        t_result r;
        int      limit;
        int      room;
        int      grow_by;
        r = '0;
        if (op == OP_ACQUIRE) begin
            if (stack_depth == 0 && fresh_high <= fresh_low) begin
                limit   = (cfg_max > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_max);
                room    = (pool_total >= limit) ? 0 : limit - pool_total;
                grow_by = (int'(cfg_grow) < room) ? int'(cfg_grow) : room;
                if (grow_by != 0) begin
                    fresh_low  = pool_total;
                    fresh_high = pool_total + grow_by;
                    pool_total += grow_by;
                    grow_total++;
                end
            end
            if (stack_depth == 0 && fresh_high <= fresh_low) begin
                r.status = ST_EXHAUSTED;
                fail_total++;
            end else begin
                // Returned indices are always handed out before fresh ones.
                if (stack_depth > 0) begin
                    stack_depth--;
                    r.granted = free_stack[stack_depth];
                end else begin
                    fresh_high--;
                    r.granted = IDX_W'(fresh_high);
                end
                r.status = ST_GRANTED;
                acq_total++;
                if (used_now < int'(USED_MAX)) used_now++;
                if (used_now > used_peak) used_peak = used_now;
            end
        end else begin
            if (int'(idx) >= pool_total) begin
                r.status = ST_INVALID;
            end else if (stack_depth >= POOL_DEPTH) begin
                r.status = ST_STACK_FULL;
            end else begin
                free_stack[stack_depth] = idx;
                stack_depth++;
                r.status = ST_RELEASED;
                rel_total++;
                if (used_now > 0) used_now--;
            end
        end
        r.in_use   = CNT_W'(used_now);
        r.peak     = CNT_W'(used_peak);
        r.total    = CNT_W'(pool_total);
        r.acq_cnt  = acq_total;
        r.rel_cnt  = rel_total;
        r.fail_cnt = fail_total;
        r.exp_cnt  = grow_total;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_setting();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CNT_W'(1);
            2: return CNT_W'(POOL_DEPTH);
            3: return '1;
            4, 5: return CNT_W'($urandom_range(2, 40));
            default: return CNT_W'($urandom_range(41, POOL_DEPTH - 1));
        endcase
    endfunction

    task automatic push_request(t_op op, logic [IDX_W-1:0] idx);
        t_result due;
        bit      taken;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(16 - IDX_W){1'b0}}, idx};
        // Inputs only move at rising edges, so the falling edge shows what
        // the next rising edge will see.
        do begin
            @(negedge i_clk);
            taken = (s_tready === 1'b1);
            @(posedge i_clk);
        end while (!taken);
        due = allocate_or_free(op, idx);
        if (pin_result) begin
            due.status     = pinned_status;
            due.granted    = pinned_granted;
            pin_result     = 1'b0;
        end
        if (due.status == ST_GRANTED) held_idx = {held_idx, int'(due.granted)};
        pending_results = {pending_results, due};
    endtask

    task automatic send_word(t_op op, logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push_request(op, idx);
    endtask

    task automatic write_register(logic [CFG_AW-1:0] addr, logic [CNT_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_INITIAL: cfg_initial = data;
            CFG_MAX:     cfg_max     = data;
            CFG_GROW:    cfg_grow    = data;
            default: ;
        endcase
        pool_reinit();
        held_idx.delete();
    endtask

    task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("word %0d: %s expected %0d, actual %0d",
                         results_seen, fname, want, got);
            mismatches++;
        end
    endtask

    // The receiver switches at random between stall patterns.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            ready_left <= 8'($urandom_range(16, 160));
        end else begin
            ready_left <= ready_left - 8'd1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= (ready_left[3:0] == 4'd0);
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
            seen_result.status   = t_status'(m_tuser);
            seen_result.granted  = m_tdata[9:0];
            seen_result.in_use   = m_tdata[20:10];
            seen_result.peak     = m_tdata[31:21];
            seen_result.total    = m_tdata[42:32];
            seen_result.acq_cnt  = m_tdata[74:43];
            seen_result.rel_cnt  = m_tdata[106:75];
            seen_result.fail_cnt = m_tdata[138:107];
            seen_result.exp_cnt  = m_tdata[170:139];
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("word %0d: result with nothing pending, status %0d",
                             results_seen, m_tuser);
                mismatches++;
            end else begin
                due_result = pending_results.pop_front();
                compare_field("status", due_result.status, seen_result.status);
                compare_field("granted_index", due_result.granted, seen_result.granted);
                compare_field("in_use", due_result.in_use, seen_result.in_use);
                compare_field("peak_in_use", due_result.peak, seen_result.peak);
                compare_field("total_buffers", due_result.total, seen_result.total);
                compare_field("acquire_count", due_result.acq_cnt, seen_result.acq_cnt);
                compare_field("release_count", due_result.rel_cnt, seen_result.rel_cnt);
                compare_field("fail_count", due_result.fail_cnt, seen_result.fail_cnt);
                compare_field("expand_count", due_result.exp_cnt, seen_result.exp_cnt);
            end
            results_seen++;
        end
    end

    initial begin
        #4_000_000;
        $display("growable_buffer_pool_free_list_top_test failed");
        $finish;
    end

    initial begin
        int               roll;
        int               pick;
        int               acquire_pct;
        logic [IDX_W-1:0] idx;

        directed_rows = '{
            // Reset pool: fresh indices go out from the top, returns come back first.
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd255},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd1023, 1'b1, ST_GRANTED,   10'd254},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd255,  1'b1, ST_RELEASED,  10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd255},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd1023, 1'b1, ST_INVALID,   10'd0},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd256,  1'b1, ST_INVALID,   10'd0},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd0,    1'b1, ST_RELEASED,  10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd253},
            // Empty pool that may grow by one index.
            '{ROW_CFG,  OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_CFG,  OP_ACQUIRE, CFG_MAX,     11'd1,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_CFG,  OP_ACQUIRE, CFG_GROW,    11'd1,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd0,    1'b1, ST_INVALID,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_EXHAUSTED, 10'd0},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd0,    1'b1, ST_RELEASED,  10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd0},
            // A zero growth step never expands.
            '{ROW_CFG,  OP_ACQUIRE, CFG_GROW,    11'd0,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_EXHAUSTED, 10'd0},
            // Settings beyond the store size act as the store size.
            '{ROW_CFG,  OP_ACQUIRE, CFG_INITIAL, 11'd2047, 1'b0, ST_GRANTED,   10'd0},
            '{ROW_CFG,  OP_ACQUIRE, CFG_MAX,     11'd2047, 1'b0, ST_GRANTED,   10'd0},
            '{ROW_CFG,  OP_ACQUIRE, CFG_GROW,    11'd2047, 1'b0, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd1023},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd1023, 1'b1, ST_RELEASED,  10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd1023},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b0, ST_GRANTED,   10'd0},
            // Initial count above the maximum: the pool starts larger and never grows.
            '{ROW_CFG,  OP_ACQUIRE, CFG_MAX,     11'd2,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_CFG,  OP_ACQUIRE, CFG_INITIAL, 11'd3,    1'b0, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd2},
            '{ROW_ITEM, OP_RELEASE, CFG_INITIAL, 11'd1,    1'b1, ST_RELEASED,  10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd1},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd1},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_GRANTED,   10'd0},
            '{ROW_ITEM, OP_ACQUIRE, CFG_INITIAL, 11'd0,    1'b1, ST_EXHAUSTED, 10'd0}
        };

        pool_reinit();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_register(directed_rows[i].addr, directed_rows[i].value);
            end else begin
                pin_result     = directed_rows[i].typed;
                pinned_status  = directed_rows[i].want_status;
                pinned_granted = directed_rows[i].want_granted;
                send_word(directed_rows[i].op, directed_rows[i].value[IDX_W-1:0]);
            end
        end

        // Fill the free stack past its depth while nothing is in use, then
        // acquire a run of words back off the full stack.
        write_register(CFG_MAX, CNT_W'(POOL_DEPTH));
        write_register(CFG_INITIAL, CNT_W'(POOL_DEPTH));
        for (int n = 0; n < FILL_RELEASES; n++)
            send_word(OP_RELEASE, IDX_W'($urandom_range(0, POOL_DEPTH - 1)));
        for (int n = 0; n < DRAIN_GRANTS; n++)
            send_word(OP_ACQUIRE, IDX_W'($urandom_range(0, POOL_DEPTH - 1)));

        // A random mix of acquires and returns of indices actually handed out, with some stray words.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_register(CFG_INITIAL, pick_setting());
            write_register(CFG_MAX, pick_setting());
            write_register(CFG_GROW, pick_setting());
            acquire_pct = $urandom_range(30, 70);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < acquire_pct || (roll < 88 && held_idx.size() == 0)) begin
                    send_word(OP_ACQUIRE, IDX_W'($urandom_range(0, POOL_DEPTH - 1)));
                end else if (roll < 88) begin
                    pick = $urandom_range(0, held_idx.size() - 1);
                    idx  = IDX_W'(held_idx[pick]);
                    held_idx.delete(pick);
                    send_word(OP_RELEASE, idx);
                end else if (roll < 95 || pool_total == 0) begin
                    send_word(OP_RELEASE, IDX_W'($urandom_range(0, POOL_DEPTH - 1)));
                end else begin
                    send_word(OP_RELEASE, IDX_W'($urandom_range(0, pool_total - 1)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("growable_buffer_pool_free_list_top_test passed");
        else
            $display("growable_buffer_pool_free_list_top_test failed");
        $finish;
    end

endmodule
